### design/rpc_pkg.sv
`timescale 1ns / 1ps
// Package for the reversible prime checker.
// Holds the field widths and stream data widths; depends on nothing.
package rpc_pkg;

  localparam int NumW     = 16;
  localparam int RadW     = 5;
  localparam int RevW     = 20;
  localparam int InDataW  = 24;
  localparam int OutDataW = 24;

endpackage

### design/reversible_prime_checker.sv
`timescale 1ns / 1ps
// Reversible prime checker: sieve memories, shared divider and request sequencer.
// Depends on rpc_pkg for field and stream widths.
//
//  channel  | dir | tdata fields, lowest bit first
//  s_axis   | in  | number[15:0], radix[20:16], zero pad to 24 bits
//  m_axis   | out | reversible[0], number_prime[1], reversed_value[21:2],
//           |     | beyond_table[22], zero pad to 24 bits
//
// After reset an initialising pass marks every map entry from two upward as prime,
// then the linear sieve runs; its inner steps use the bit-serial divider, DW bits
// wide, and no request is taken until the sieve is complete.
// A request looks up the number, splits it into radix digits with the divider and
// looks up the reversed value; a radix below two skips the digits and that lookup.
// A finished result waits in the output register while the next request is taken.

module reversible_prime_checker #(
  parameter int TABLE_SIZE  = 65536,
  parameter int PRIME_SLOTS = 8192
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // number[15:0], radix[20:16]
  input  logic [rpc_pkg::InDataW-1:0]   s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // reversible[0], number_prime[1], reversed_value[21:2], beyond_table[22]
  output logic [rpc_pkg::OutDataW-1:0]  m_axis_tdata_o
);

  localparam int AW  = $clog2(TABLE_SIZE);
  localparam int LW  = $clog2(PRIME_SLOTS);
  localparam int CW  = $clog2(PRIME_SLOTS + 1);
  localparam int DW  = (AW > rpc_pkg::NumW) ? AW : rpc_pkg::NumW;
  localparam int DCW = $clog2(DW + 1);
  localparam int PW  = 2 * AW + 1;
  localparam int MW  = rpc_pkg::RevW + rpc_pkg::RadW;

  localparam logic [31:0]   TsWide  = 32'(TABLE_SIZE);
  localparam logic [PW-1:0] TsProd  = PW'(TABLE_SIZE);
  localparam logic [AW-1:0] LastIdx = AW'(TABLE_SIZE - 1);
  localparam logic [CW-1:0] SlotsC  = CW'(PRIME_SLOTS);

  typedef enum logic [3:0] {
    S_INIT, S_RD_I, S_CHK_I, S_RD_P, S_MUL, S_STRIKE, S_SDIV,
    S_IDLE, S_RDN, S_GETN, S_DIGIT, S_QDIV, S_RDR, S_GETR, S_FIN
  } state_e;

  state_e                      state_q;
  logic [AW-1:0]               idx_q;
  logic [CW-1:0]               count_q;
  logic [CW-1:0]               k_q;
  logic [AW-1:0]               p_q;
  logic [PW-1:0]               prod_q;
  logic [rpc_pkg::NumW-1:0]    num_q;
  logic [rpc_pkg::RadW-1:0]    rad_q;
  logic [rpc_pkg::NumW-1:0]    rest_q;
  logic [rpc_pkg::RevW-1:0]    rev_q;
  logic                        np_q;
  logic                        rp_q;
  logic                        beyond_q;
  logic                        m_valid_q;
  logic [rpc_pkg::OutDataW-1:0] m_data_q;

  logic                        map_mem [TABLE_SIZE];
  logic                        map_we;
  logic [AW-1:0]               map_waddr;
  logic                        map_wdata;
  logic [AW-1:0]               map_raddr;
  logic                        map_rd_q;

  logic [AW-1:0]               list_mem [PRIME_SLOTS];
  logic                        list_we;
  logic [LW-1:0]               list_waddr;
  logic [AW-1:0]               list_wdata;
  logic [LW-1:0]               list_raddr;
  logic [AW-1:0]               list_rd_q;

  logic                        div_start;
  logic [DW-1:0]               div_dvd;
  logic [DW-1:0]               div_dvs;
  logic                        div_busy_q;
  logic [DCW-1:0]              div_cnt_q;
  logic [DW-1:0]               div_quo_q;
  logic [DW-1:0]               div_rem_q;
  logic [DW-1:0]               div_dvs_q;
  logic [DW:0]                 div_trial;
  logic                        div_ge;

  logic                        prod_big;
  logic                        list_room;

  assign prod_big  = (prod_q >= TsProd);
  assign list_room = (count_q < SlotsC);

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  always_comb begin
    map_we     = 1'b0;
    map_waddr  = idx_q;
    map_wdata  = 1'b0;
    map_raddr  = idx_q;
    list_we    = 1'b0;
    list_waddr = count_q[LW-1:0];
    list_wdata = idx_q;
    list_raddr = k_q[LW-1:0];
    div_start  = 1'b0;
    div_dvd    = DW'(idx_q);
    div_dvs    = DW'(p_q);
    case (state_q)
      S_INIT: begin
        map_we    = 1'b1;
        map_wdata = (idx_q >= AW'(2));
      end
      S_CHK_I: begin
        list_we = map_rd_q && list_room;
      end
      S_STRIKE: begin
        if (!prod_big) begin
          map_we    = 1'b1;
          map_waddr = prod_q[AW-1:0];
          div_start = 1'b1;
        end
      end
      S_RDN: begin
        map_raddr = AW'(num_q);
      end
      S_DIGIT: begin
        div_dvd = DW'(rest_q);
        div_dvs = DW'(rad_q);
        div_start = (rest_q != '0);
      end
      S_RDR: begin
        map_raddr = AW'(rev_q);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    map_rd_q <= map_mem[map_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (list_we) begin
      list_mem[list_waddr] <= list_wdata;
    end
    list_rd_q <= list_mem[list_raddr];
  end

  assign div_trial = {div_rem_q, div_quo_q[DW-1]};
  assign div_ge    = (div_trial >= {1'b0, div_dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0;
      div_cnt_q  <= '0;
      div_quo_q  <= '0;
      div_rem_q  <= '0;
      div_dvs_q  <= '0;
    end else if (div_start) begin
      div_busy_q <= 1'b1;
      div_cnt_q  <= DCW'(DW);
      div_quo_q  <= div_dvd;
      div_rem_q  <= '0;
      div_dvs_q  <= div_dvs;
    end else if (div_busy_q) begin
      div_cnt_q  <= div_cnt_q - DCW'(1);
      div_busy_q <= (div_cnt_q != DCW'(1));
      if (div_ge) begin
        div_rem_q <= DW'(div_trial - {1'b0, div_dvs_q});
        div_quo_q <= {div_quo_q[DW-2:0], 1'b1};
      end else begin
        div_rem_q <= div_trial[DW-1:0];
        div_quo_q <= {div_quo_q[DW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_INIT;
      idx_q     <= '0;
      count_q   <= '0;
      k_q       <= '0;
      p_q       <= '0;
      prod_q    <= '0;
      num_q     <= '0;
      rad_q     <= '0;
      rest_q    <= '0;
      rev_q     <= '0;
      np_q      <= 1'b0;
      rp_q      <= 1'b0;
      beyond_q  <= 1'b0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else begin
      if (m_valid_q && m_axis_tready_i && state_q != S_FIN) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_INIT: begin
          if (idx_q == LastIdx) begin
            idx_q   <= AW'(2);
            state_q <= S_RD_I;
          end else begin
            idx_q <= idx_q + AW'(1);
          end
        end
        S_RD_I: begin
          state_q <= S_CHK_I;
        end
        S_CHK_I: begin
          if (map_rd_q && list_room) begin
            count_q <= count_q + CW'(1);
          end
          k_q     <= '0;
          state_q <= S_RD_P;
        end
        S_RD_P: begin
          if (k_q >= count_q) begin
            if (idx_q == LastIdx) begin
              state_q <= S_IDLE;
            end else begin
              idx_q   <= idx_q + AW'(1);
              state_q <= S_RD_I;
            end
          end else begin
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          p_q     <= list_rd_q;
          prod_q  <= PW'(idx_q) * PW'(list_rd_q);
          state_q <= S_STRIKE;
        end
        S_STRIKE: begin
          if (prod_big) begin
            if (idx_q == LastIdx) begin
              state_q <= S_IDLE;
            end else begin
              idx_q   <= idx_q + AW'(1);
              state_q <= S_RD_I;
            end
          end else begin
            state_q <= S_SDIV;
          end
        end
        S_SDIV: begin
          if (!div_busy_q) begin
            if (div_rem_q == '0) begin
              if (idx_q == LastIdx) begin
                state_q <= S_IDLE;
              end else begin
                idx_q   <= idx_q + AW'(1);
                state_q <= S_RD_I;
              end
            end else begin
              k_q     <= k_q + CW'(1);
              state_q <= S_RD_P;
            end
          end
        end
        S_IDLE: begin
          if (s_axis_tvalid_i) begin
            num_q   <= s_axis_tdata_i[rpc_pkg::NumW-1:0];
            rad_q   <= s_axis_tdata_i[rpc_pkg::NumW +: rpc_pkg::RadW];
            state_q <= S_RDN;
          end
        end
        S_RDN: begin
          state_q <= S_GETN;
        end
        S_GETN: begin
          np_q     <= (32'(num_q) < TsWide) && map_rd_q;
          rest_q   <= num_q;
          rev_q    <= '0;
          rp_q     <= 1'b0;
          beyond_q <= 1'b0;
          if (rad_q < rpc_pkg::RadW'(2)) begin
            state_q <= S_FIN;
          end else begin
            state_q <= S_DIGIT;
          end
        end
        S_DIGIT: begin
          if (rest_q == '0) begin
            state_q <= S_RDR;
          end else begin
            state_q <= S_QDIV;
          end
        end
        S_QDIV: begin
          if (!div_busy_q) begin
            rest_q  <= rpc_pkg::NumW'(div_quo_q);
            rev_q   <= rpc_pkg::RevW'(MW'(rev_q) * MW'(rad_q) + MW'(div_rem_q));
            state_q <= S_DIGIT;
          end
        end
        S_RDR: begin
          state_q <= S_GETR;
        end
        S_GETR: begin
          beyond_q <= (32'(rev_q) >= TsWide);
          rp_q     <= (32'(rev_q) < TsWide) && map_rd_q;
          state_q  <= S_FIN;
        end
        S_FIN: begin
          if (!m_valid_q || m_axis_tready_i) begin
            m_valid_q <= 1'b1;
            m_data_q  <= rpc_pkg::OutDataW'({beyond_q, rev_q, np_q, np_q & rp_q});
            state_q   <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy_q)
    else $error("divider started while busy");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= SlotsC)
    else $error("prime count beyond list size");

  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == S_FIN))
    else $error("result raised outside the finishing step");

  a_strike_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (map_we && state_q != S_INIT) |-> (!map_wdata && map_waddr > idx_q))
    else $error("sieve write does not clear a later entry");

endmodule
